// File: hdl/vpk_pkg.sv
// Shared types, constants and register codes of the RFC 4175 video packetizer.
package vpk_pkg;

    localparam int MAX_WIDTH     = 4096;
    localparam int MAX_LINES     = 4096;
    localparam int MAX_SEGMENTS  = 3;
    localparam int PGROUP_BYTES  = 5;
    localparam int SEG_HDR_BYTES = 6;
    localparam int EXT_SEQ_BYTES = 2;
    localparam int MIN_WIDTH     = 512;
    localparam int MIN_PAYLOAD   = 64;
    localparam int MAX_PAYLOAD   = 1500;

    // Segment planning continues while more than a header plus one pgroup fits.
    localparam int MIN_LEFT = SEG_HDR_BYTES + PGROUP_BYTES;

    // Reciprocal of five, exact for all payload byte counts below 2048.
    localparam int RECIP5       = 6554;
    localparam int RECIP5_SHIFT = 15;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [1:0] REG_FRAME_WIDTH   = 2'd0;
    localparam logic [1:0] REG_FRAME_HEIGHT  = 2'd1;
    localparam logic [1:0] REG_PAYLOAD_BYTES = 2'd2;

    localparam logic [12:0] WIDTH_RESET   = 13'd1920;
    localparam logic [12:0] HEIGHT_RESET  = 13'd1080;
    localparam logic [10:0] PAYLOAD_RESET = 11'd1448;

    localparam logic [1:0] KIND_PKT_HDR = 2'd0;
    localparam logic [1:0] KIND_SEG_HDR = 2'd1;
    localparam logic [1:0] KIND_PGROUP  = 2'd2;

    typedef enum logic [2:0] {
        ST_RUN,
        ST_START,
        ST_PLAN,
        ST_HDR,
        ST_SEG
    } state_t;

    // Saturated configuration as the datapath uses it.
    typedef struct packed {
        logic [12:0] width;
        logic [12:0] height;
        logic [10:0] payload;
    } cfg_t;

    typedef struct packed {
        logic [10:0] length;
        logic [11:0] line;
        logic [11:0] offset;
        logic        cont;
    } seg_t;

    // One planned segment and the planner state that follows it.
    typedef struct packed {
        seg_t        seg;
        logic [10:0] left;
        logic [12:0] line;
        logic [11:0] offset;
        logic [8:0]  pgroups;
    } step_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] seq_number;
        logic        marker;
        logic        frame_first;
        logic [10:0] seg_length;
        logic [11:0] seg_line;
        logic [11:0] seg_offset;
        logic        seg_continue;
        logic [39:0] pgroup_bits;
        logic        packet_last;
    } out_item_t;

endpackage

// File: hdl/vpk_cfg_regs.sv
// APB register file with saturation of the frame and payload settings.
module vpk_cfg_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [vpk_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [vpk_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [vpk_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready,
    output vpk_pkg::cfg_t                    cfg
);

    logic [12:0] frame_width_reg;
    logic [12:0] frame_height_reg;
    logic [10:0] payload_bytes_reg;
    logic [1:0]  reg_index;
    logic        wr_en;
    logic [12:0] width_even;

    assign reg_index = paddr[3:2];
    assign pready    = 1'b1;
    assign wr_en     = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg   <= vpk_pkg::WIDTH_RESET;
            frame_height_reg  <= vpk_pkg::HEIGHT_RESET;
            payload_bytes_reg <= vpk_pkg::PAYLOAD_RESET;
        end else if (wr_en) begin
            unique case (reg_index)
                vpk_pkg::REG_FRAME_WIDTH:   frame_width_reg   <= pwdata[12:0];
                vpk_pkg::REG_FRAME_HEIGHT:  frame_height_reg  <= pwdata[12:0];
                vpk_pkg::REG_PAYLOAD_BYTES: payload_bytes_reg <= pwdata[10:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_index)
            vpk_pkg::REG_FRAME_WIDTH:   prdata = 32'(frame_width_reg);
            vpk_pkg::REG_FRAME_HEIGHT:  prdata = 32'(frame_height_reg);
            vpk_pkg::REG_PAYLOAD_BYTES: prdata = 32'(payload_bytes_reg);
            default:                    prdata = '0;
        endcase
    end

    // Drop the odd bit of the width, then saturate all three settings.
    assign width_even = {frame_width_reg[12:1], 1'b0};

    always_comb begin
        if (width_even < 13'(vpk_pkg::MIN_WIDTH)) begin
            cfg.width = 13'(vpk_pkg::MIN_WIDTH);
        end else if (width_even > 13'(vpk_pkg::MAX_WIDTH)) begin
            cfg.width = 13'(vpk_pkg::MAX_WIDTH);
        end else begin
            cfg.width = width_even;
        end

        if (frame_height_reg == 13'd0) begin
            cfg.height = 13'd1;
        end else if (frame_height_reg > 13'(vpk_pkg::MAX_LINES)) begin
            cfg.height = 13'(vpk_pkg::MAX_LINES);
        end else begin
            cfg.height = frame_height_reg;
        end

        if (payload_bytes_reg < 11'(vpk_pkg::MIN_PAYLOAD)) begin
            cfg.payload = 11'(vpk_pkg::MIN_PAYLOAD);
        end else if (payload_bytes_reg > 11'(vpk_pkg::MAX_PAYLOAD)) begin
            cfg.payload = 11'(vpk_pkg::MAX_PAYLOAD);
        end else begin
            cfg.payload = payload_bytes_reg;
        end
    end

endmodule

// File: hdl/vpk_seg_step.sv
// One step of segment planning: size one segment against the remaining budget.
module vpk_seg_step (
    input  vpk_pkg::cfg_t  cfg,
    input  logic [10:0]    left,
    input  logic [12:0]    line,
    input  logic [11:0]    offset,
    input  logic [1:0]     seg_index,
    output vpk_pkg::step_t step
);

    logic [10:0] budget;
    logic [12:0] pixels_full;
    logic [14:0] bytes_x2;
    logic [13:0] len_full;
    logic        whole;
    logic [23:0] recip_prod;
    logic [8:0]  quot;
    logic [10:0] len_part;
    logic [10:0] length;

    assign budget      = left - 11'(vpk_pkg::SEG_HDR_BYTES);
    assign pixels_full = cfg.width - {1'b0, offset};
    // Pixels are even, so five halves of them is exact.
    assign bytes_x2    = {pixels_full, 2'b00} + 15'(pixels_full);
    assign len_full    = bytes_x2[14:1];
    assign whole       = 14'(budget) >= len_full;

    // Whole pgroups that fit: budget / 5 by reciprocal multiply.
    assign recip_prod = 24'(budget) * 24'(vpk_pkg::RECIP5);
    assign quot       = recip_prod[vpk_pkg::RECIP5_SHIFT +: 9];
    assign len_part   = {quot, 2'b00} + 11'(quot);

    assign length = whole ? len_full[10:0] : len_part;

    always_comb begin
        step.left         = budget - length;
        step.seg.length   = length;
        step.seg.line     = line[11:0];
        step.seg.offset   = offset;
        if (whole) begin
            step.line    = line + 13'd1;
            step.offset  = '0;
            step.pgroups = pixels_full[9:1];
        end else begin
            step.line    = line;
            step.offset  = offset + {2'b00, quot, 1'b0};
            step.pgroups = quot;
        end
        step.seg.cont = (step.left > 11'(vpk_pkg::MIN_LEFT))
                     && (step.line < cfg.height)
                     && (seg_index < 2'(vpk_pkg::MAX_SEGMENTS - 1));
    end

endmodule

// File: hdl/rfc4175_video_packetizer_unit.sv
// Top level of the RFC 4175 4:2:2 10-bit packetizer: sequencer and output register.
//
//  channel | direction | words                                  | handshake
//  s_axis  | in        | one pixel pair (cb, luma0, cr, luma1)  | tvalid/tready
//  m_axis  | out       | packet header, segment header, pgroup  | tvalid/tready/tlast
//  apb     | in        | frame_width, frame_height, payload     | psel/penable, pready=1
//
// Inside a packet one pixel pair enters and one pgroup word leaves every cycle
// while m_tready is high. A pixel pair that opens a packet waits while the
// sequencer steps through, in order: a check that a packet must open, a
// normalization of the position, one plan step per segment (one to three) in the
// shared step unit, the packet header and one segment header per segment.
// Reset is synchronous; it returns the block to line 0, sequence 0, frame start.
// A stalled m_tready holds the output word; the input register still takes one word.
module rfc4175_video_packetizer_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [31:0]                    s_tdata,  // cb, luma0, cr, luma1
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // seq_number, marker, frame_first, seg_length, seg_line, seg_offset,
    // seg_continue, pgroup_bits, zero fill
    output logic [95:0]                    m_tdata,
    output logic [1:0]                     m_tuser,  // item_kind
    output logic                           m_tlast,  // packet_last
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [vpk_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [vpk_pkg::APB_DATA_W-1:0] pwdata,
    output logic [vpk_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);

    vpk_pkg::cfg_t      cfg;
    vpk_pkg::step_t     step;
    vpk_pkg::state_t    state_reg, state_next;

    logic               hold_valid_reg, hold_valid_next;
    logic [39:0]        hold_bits_reg, hold_bits_next;
    logic [8:0]         pgroups_left_reg, pgroups_left_next;
    logic [15:0]        sequence_reg, sequence_next;
    logic               frame_start_reg, frame_start_next;
    logic [12:0]        plan_line_reg, plan_line_next;
    logic [11:0]        plan_offset_reg, plan_offset_next;
    logic [10:0]        left_reg, left_next;
    logic [8:0]         total_reg, total_next;
    logic [1:0]         nseg_reg, nseg_next;
    logic [1:0]         seg_idx_reg, seg_idx_next;
    vpk_pkg::seg_t      seg_reg [vpk_pkg::MAX_SEGMENTS];
    logic               seg_wr;
    logic               m_valid_reg, m_valid_next;
    vpk_pkg::out_item_t m_item_reg, m_item_next;

    logic               out_free;
    logic               out_load;
    logic               hold_take;
    logic               s_accept;
    logic [12:0]        norm_line;
    logic [11:0]        norm_offset;
    logic               norm_wrap;
    logic [8:0]         pgroups_dec;

    vpk_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    vpk_seg_step u_step (
        .cfg       (cfg),
        .left      (left_reg),
        .line      (plan_line_reg),
        .offset    (plan_offset_reg),
        .seg_index (nseg_reg),
        .step      (step)
    );

    assign out_free  = !m_valid_reg || m_tready;
    assign hold_take = (state_reg == vpk_pkg::ST_RUN) && hold_valid_reg
                    && (pgroups_left_reg != 9'd0) && out_free;
    assign s_tready  = !hold_valid_reg || hold_take;
    assign s_accept  = s_tvalid && s_tready;
    assign pgroups_dec = pgroups_left_reg - 9'd1;

    // Close a line cut short by a width change, then wrap past the last line.
    always_comb begin
        norm_line   = plan_line_reg;
        norm_offset = plan_offset_reg;
        norm_wrap   = 1'b0;
        if ({1'b0, plan_offset_reg} >= cfg.width) begin
            norm_offset = '0;
            norm_line   = plan_line_reg + 13'd1;
        end
        if (norm_line >= cfg.height) begin
            norm_line   = '0;
            norm_offset = '0;
            norm_wrap   = 1'b1;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            vpk_pkg::ST_RUN: begin
                if (hold_valid_reg && (pgroups_left_reg == 9'd0)) begin
                    state_next = vpk_pkg::ST_START;
                end
            end
            vpk_pkg::ST_START: state_next = vpk_pkg::ST_PLAN;
            vpk_pkg::ST_PLAN: begin
                if (!step.seg.cont) begin
                    state_next = vpk_pkg::ST_HDR;
                end
            end
            vpk_pkg::ST_HDR: begin
                if (out_free) begin
                    state_next = vpk_pkg::ST_SEG;
                end
            end
            vpk_pkg::ST_SEG: begin
                if (out_free && (seg_idx_reg + 2'd1 == nseg_reg)) begin
                    state_next = vpk_pkg::ST_RUN;
                end
            end
            default: state_next = vpk_pkg::ST_RUN;
        endcase
    end

    always_comb begin
        hold_valid_next   = hold_valid_reg;
        hold_bits_next    = hold_bits_reg;
        pgroups_left_next = pgroups_left_reg;
        sequence_next     = sequence_reg;
        frame_start_next  = frame_start_reg;
        plan_line_next    = plan_line_reg;
        plan_offset_next  = plan_offset_reg;
        left_next         = left_reg;
        total_next        = total_reg;
        nseg_next         = nseg_reg;
        seg_idx_next      = seg_idx_reg;
        seg_wr            = 1'b0;
        out_load          = 1'b0;
        m_item_next       = m_item_reg;

        if (hold_take) begin
            hold_valid_next = 1'b0;
        end
        if (s_accept) begin
            hold_valid_next = 1'b1;
            hold_bits_next  = {s_tdata[7:0], 2'b00, s_tdata[15:8], 2'b00,
                               s_tdata[23:16], 2'b00, s_tdata[31:24], 2'b00};
        end

        unique case (state_reg)
            vpk_pkg::ST_RUN: begin
                if (hold_take) begin
                    out_load                = 1'b1;
                    m_item_next             = '0;
                    m_item_next.kind        = vpk_pkg::KIND_PGROUP;
                    m_item_next.pgroup_bits = hold_bits_reg;
                    m_item_next.packet_last = (pgroups_dec == 9'd0);
                    pgroups_left_next       = pgroups_dec;
                end
            end
            vpk_pkg::ST_START: begin
                plan_line_next   = norm_line;
                plan_offset_next = norm_offset;
                if (norm_wrap) begin
                    frame_start_next = 1'b1;
                end
                left_next  = cfg.payload - 11'(vpk_pkg::EXT_SEQ_BYTES);
                total_next = '0;
                nseg_next  = '0;
            end
            vpk_pkg::ST_PLAN: begin
                seg_wr           = 1'b1;
                left_next        = step.left;
                plan_line_next   = step.line;
                plan_offset_next = step.offset;
                total_next       = total_reg + step.pgroups;
                nseg_next        = nseg_reg + 2'd1;
            end
            vpk_pkg::ST_HDR: begin
                if (out_free) begin
                    out_load                = 1'b1;
                    m_item_next             = '0;
                    m_item_next.kind        = vpk_pkg::KIND_PKT_HDR;
                    m_item_next.seq_number  = sequence_reg + 16'd1;
                    m_item_next.marker      = (plan_line_reg >= cfg.height);
                    m_item_next.frame_first = frame_start_reg;
                    sequence_next           = sequence_reg + 16'd1;
                    frame_start_next        = 1'b0;
                    pgroups_left_next       = total_reg;
                    seg_idx_next            = '0;
                end
            end
            vpk_pkg::ST_SEG: begin
                if (out_free) begin
                    out_load                 = 1'b1;
                    m_item_next              = '0;
                    m_item_next.kind         = vpk_pkg::KIND_SEG_HDR;
                    m_item_next.seg_length   = seg_reg[seg_idx_reg].length;
                    m_item_next.seg_line     = seg_reg[seg_idx_reg].line;
                    m_item_next.seg_offset   = seg_reg[seg_idx_reg].offset;
                    m_item_next.seg_continue = seg_reg[seg_idx_reg].cont;
                    seg_idx_next             = seg_idx_reg + 2'd1;
                end
            end
            default: ;
        endcase

        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= vpk_pkg::ST_RUN;
            hold_valid_reg   <= 1'b0;
            pgroups_left_reg <= '0;
            sequence_reg     <= '0;
            frame_start_reg  <= 1'b1;
            plan_line_reg    <= '0;
            plan_offset_reg  <= '0;
            nseg_reg         <= '0;
            seg_idx_reg      <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            hold_valid_reg   <= hold_valid_next;
            pgroups_left_reg <= pgroups_left_next;
            sequence_reg     <= sequence_next;
            frame_start_reg  <= frame_start_next;
            plan_line_reg    <= plan_line_next;
            plan_offset_reg  <= plan_offset_next;
            nseg_reg         <= nseg_next;
            seg_idx_reg      <= seg_idx_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        hold_bits_reg <= hold_bits_next;
        left_reg      <= left_next;
        total_reg     <= total_next;
        m_item_reg    <= m_item_next;
        if (seg_wr) begin
            seg_reg[nseg_reg] <= step.seg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_item_reg.kind;
    assign m_tlast  = m_item_reg.packet_last;
    assign m_tdata  = {2'b00, m_item_reg.pgroup_bits, m_item_reg.seg_continue,
                       m_item_reg.seg_offset, m_item_reg.seg_line,
                       m_item_reg.seg_length, m_item_reg.frame_first,
                       m_item_reg.marker, m_item_reg.seq_number};

endmodule

// File: test/vpk_stream_checker.sv
// Monitor and predictor for the RFC 4175 packetizer: tracks registers, predicts words, compares.
module vpk_stream_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [31:0]                    s_tdata,     // cb, luma0, cr, luma1
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    // seq_number, marker, frame_first, seg_length, seg_line, seg_offset,
    // seg_continue, pgroup_bits, zero fill
    input  logic [95:0]                    m_tdata,
    input  logic [1:0]                     m_tuser,     // item_kind
    input  logic                           m_tlast,     // packet_last
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic                           pready,
    input  logic [vpk_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [vpk_pkg::APB_DATA_W-1:0] pwdata,
    output int                             failures,
    output int                             pending,
    output int                             words_seen,
    output int                             frame_ends
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [12:0] cfg_width;
    logic [12:0] cfg_height;
    logic [10:0] cfg_payload;

    logic [12:0] plan_line;
    logic [11:0] plan_offset;
    logic [8:0]  pgroups_left;
    logic [15:0] seq_count;
    logic        frame_pending;

    vpk_pkg::out_item_t packet_words[$];

    function automatic int unsigned clamp_range(int unsigned v, int unsigned lo,
                                                int unsigned hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    task automatic append_word(input vpk_pkg::out_item_t w);
        packet_words.insert(packet_words.size(), w);
    endtask

    task automatic take_word(output vpk_pkg::out_item_t w);
        w = packet_words[0];
        packet_words.delete(0);
    endtask

    // Append the words that one pixel pair produces: headers when a packet opens,
    // then its pgroup.
    task automatic packetize_pair(input logic [31:0] pair);
        int unsigned        width;
        int unsigned        height;
        int unsigned        left;
        int unsigned        segs;
        int unsigned        total;
        int unsigned        pixels;
        int unsigned        length;
        bit                 whole;
        vpk_pkg::seg_t      plan [vpk_pkg::MAX_SEGMENTS];
        vpk_pkg::out_item_t w;
        width  = clamp_range(32'({cfg_width[12:1], 1'b0}), vpk_pkg::MIN_WIDTH,
                             vpk_pkg::MAX_WIDTH);
        height = clamp_range(32'(cfg_height), 1, vpk_pkg::MAX_LINES);
        if (pgroups_left == 9'd0) begin
            left  = clamp_range(32'(cfg_payload), vpk_pkg::MIN_PAYLOAD,
                                vpk_pkg::MAX_PAYLOAD) - vpk_pkg::EXT_SEQ_BYTES;
            segs  = 0;
            total = 0;
            // finish a line that a narrower width has cut short
            if (32'(plan_offset) >= width) begin
                plan_offset = '0;
                plan_line   = plan_line + 13'd1;
            end
            if (32'(plan_line) >= height) begin
                plan_line     = '0;
                plan_offset   = '0;
                frame_pending = 1'b1;
            end
            while (left > vpk_pkg::MIN_LEFT && segs < vpk_pkg::MAX_SEGMENTS) begin
                left   -= vpk_pkg::SEG_HDR_BYTES;
                pixels  = width - 32'(plan_offset);
                length  = (pixels * vpk_pkg::PGROUP_BYTES) / 2;
                whole   = (left >= length);
                if (!whole) begin
                    pixels = (left / vpk_pkg::PGROUP_BYTES) * 2;
                    length = (pixels * vpk_pkg::PGROUP_BYTES) / 2;
                end
                left -= length;
                plan[segs].length = 11'(length);
                plan[segs].line   = 12'(plan_line);
                plan[segs].offset = plan_offset;
                total += length / vpk_pkg::PGROUP_BYTES;
                if (whole) begin
                    plan_line   = plan_line + 13'd1;
                    plan_offset = '0;
                end else begin
                    plan_offset = 12'(32'(plan_offset) + pixels);
                end
                plan[segs].cont = (left > vpk_pkg::MIN_LEFT) && (32'(plan_line) < height) &&
                                  (segs + 1 < vpk_pkg::MAX_SEGMENTS);
                segs++;
                if (!plan[segs-1].cont) break;
            end
            seq_count     = seq_count + 16'd1;
            w             = '0;
            w.kind        = vpk_pkg::KIND_PKT_HDR;
            w.seq_number  = seq_count;
            w.marker      = (32'(plan_line) >= height);
            w.frame_first = frame_pending;
            append_word(w);
            frame_pending = 1'b0;
            for (int i = 0; i < segs; i++) begin
                w              = '0;
                w.kind         = vpk_pkg::KIND_SEG_HDR;
                w.seg_length   = plan[i].length;
                w.seg_line     = plan[i].line;
                w.seg_offset   = plan[i].offset;
                w.seg_continue = plan[i].cont;
                append_word(w);
            end
            pgroups_left = 9'(total);
        end
        if (pgroups_left > 9'd0) pgroups_left = pgroups_left - 9'd1;
        w             = '0;
        w.kind        = vpk_pkg::KIND_PGROUP;
        w.pgroup_bits = {pair[7:0], 2'b00, pair[15:8], 2'b00,
                         pair[23:16], 2'b00, pair[31:24], 2'b00};
        w.packet_last = (pgroups_left == 9'd0);
        append_word(w);
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            failures++;
        end
    endtask

    task automatic compare_word(input vpk_pkg::out_item_t got, input logic [1:0] fill);
        vpk_pkg::out_item_t want;
        if (packet_words.size() == 0) begin
            $error("word of kind %0d arrived with nothing outstanding", got.kind);
            failures++;
            return;
        end
        take_word(want);
        words_seen++;
        check_field("item_kind",    64'(want.kind),         64'(got.kind));
        check_field("seq_number",   64'(want.seq_number),   64'(got.seq_number));
        check_field("marker",       64'(want.marker),       64'(got.marker));
        check_field("frame_first",  64'(want.frame_first),  64'(got.frame_first));
        check_field("seg_length",   64'(want.seg_length),   64'(got.seg_length));
        check_field("seg_line",     64'(want.seg_line),     64'(got.seg_line));
        check_field("seg_offset",   64'(want.seg_offset),   64'(got.seg_offset));
        check_field("seg_continue", 64'(want.seg_continue), 64'(got.seg_continue));
        check_field("pgroup_bits",  64'(want.pgroup_bits),  64'(got.pgroup_bits));
        check_field("packet_last",  64'(want.packet_last),  64'(got.packet_last));
        check_field("zero_fill",    64'd0,                  64'(fill));
        if (want.kind == vpk_pkg::KIND_PKT_HDR && want.marker) frame_ends++;
    endtask

    always @(posedge aclk) begin : monitor
        vpk_pkg::out_item_t got;
        if (!aresetn) begin
            cfg_width     = vpk_pkg::WIDTH_RESET;
            cfg_height    = vpk_pkg::HEIGHT_RESET;
            cfg_payload   = vpk_pkg::PAYLOAD_RESET;
            plan_line     = '0;
            plan_offset   = '0;
            pgroups_left  = '0;
            seq_count     = '0;
            frame_pending = 1'b1;
            packet_words.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    vpk_pkg::REG_FRAME_WIDTH:   cfg_width   = pwdata[12:0];
                    vpk_pkg::REG_FRAME_HEIGHT:  cfg_height  = pwdata[12:0];
                    vpk_pkg::REG_PAYLOAD_BYTES: cfg_payload = pwdata[10:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) packetize_pair(s_tdata);
            if (m_tvalid && m_tready) begin
                got              = '0;
                got.kind         = m_tuser;
                got.seq_number   = m_tdata[15:0];
                got.marker       = m_tdata[16];
                got.frame_first  = m_tdata[17];
                got.seg_length   = m_tdata[28:18];
                got.seg_line     = m_tdata[40:29];
                got.seg_offset   = m_tdata[52:41];
                got.seg_continue = m_tdata[53];
                got.pgroup_bits  = m_tdata[93:54];
                got.packet_last  = m_tlast;
                compare_word(got, m_tdata[95:94]);
            end
        end
        pending = packet_words.size();
    end

endmodule

// File: test/rfc4175_video_packetizer_unit_tb.sv
// Stimulus, register programming and verdict for the RFC 4175 packetizer.
module rfc4175_video_packetizer_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PAIR_TARGET    = 420;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SQUEEZE_CYCLES = 400;
    localparam int TAIL_CYCLES    = 40;

    localparam logic [31:0] PIXEL_PATTERNS [12] = '{
        32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_00FF, 32'h0000_FF00,
        32'h00FF_0000, 32'hFF00_0000, 32'h5555_5555, 32'hAAAA_AAAA,
        32'h8080_8080, 32'h7F7F_7F7F, 32'h0101_0101, 32'hFEFE_FEFE
    };

    logic                           aclk;
    logic                           aresetn;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [31:0]                    s_tdata;   // cb, luma0, cr, luma1
    logic                           m_tvalid;
    logic                           m_tready;
    // seq_number, marker, frame_first, seg_length, seg_line, seg_offset,
    // seg_continue, pgroup_bits, zero fill
    logic [95:0]                    m_tdata;
    logic [1:0]                     m_tuser;   // item_kind
    logic                           m_tlast;   // packet_last
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [vpk_pkg::APB_ADDR_W-1:0] paddr;
    logic [vpk_pkg::APB_DATA_W-1:0] pwdata;
    logic [vpk_pkg::APB_DATA_W-1:0] prdata;
    logic                           pready;

    int failures;
    int pending;
    int words_seen;
    int frame_ends;
    int pairs_sent    = 0;
    int settings_run  = 0;
    int stall_cycles  = 0;
    bit squeeze       = 1'b0;

    rfc4175_video_packetizer_unit u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    vpk_stream_checker u_monitor (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .failures   (failures),
        .pending    (pending),
        .words_seen (words_seen),
        .frame_ends (frame_ends)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin : watchdog
        wait (stall_cycles >= WATCHDOG_LIMIT);
        $display("rfc4175_video_packetizer_unit_tb: done, errors");
        $finish;
    end

    // Mostly back to back, sometimes a short gap, now and then a long one.
    function automatic int idle_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic push_pair(input logic [31:0] pair);
        int gap;
        gap = idle_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = pair;
        do @(posedge aclk); while (!s_tready);
        pairs_sent++;
    endtask

    task automatic drain();
        @(negedge aclk);
        s_tvalid = 1'b0;
        wait (pending == 0);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
        @(negedge aclk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {index, 2'b00};
        pwdata  = value;
        @(negedge aclk);
        penable = 1'b1;
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Reprogram only with every predicted word already out.
    task automatic apply_setting(input int w, input int h, input int p);
        drain();
        write_reg(vpk_pkg::REG_FRAME_WIDTH, w);
        write_reg(vpk_pkg::REG_FRAME_HEIGHT, h);
        write_reg(vpk_pkg::REG_PAYLOAD_BYTES, p);
        settings_run++;
    endtask

    initial begin : receiver
        int run;
        int stall;
        m_tready = 1'b0;
        wait (aresetn);
        forever begin
            if (squeeze) begin
                // hold off long enough to back up the input side
                m_tready = 1'b0;
                repeat (SQUEEZE_CYCLES) @(negedge aclk);
                squeeze = 1'b0;
            end
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 12);
            m_tready = 1'b1;
            for (int k = 0; k < run && !squeeze; k++) @(negedge aclk);
            stall = idle_gap();
            if (stall > 0 && !squeeze) begin
                m_tready = 1'b0;
                for (int k = 0; k < stall && !squeeze; k++) @(negedge aclk);
            end
        end
    end

    initial begin : stimulus
        int phase;
        int chunk;
        int w;
        int h;
        int p;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (10) @(negedge aclk);
        aresetn = 1'b1;

        // field extremes under the reset configuration
        foreach (PIXEL_PATTERNS[i]) push_pair(PIXEL_PATTERNS[i]);
        // saturation from below, from above, and an odd width
        apply_setting(0, 0, 0);
        repeat (4) push_pair($urandom());
        apply_setting(8191, 8191, 2047);
        repeat (4) push_pair($urandom());
        apply_setting(513, 1, 1500);
        repeat (4) push_pair($urandom());

        phase = 0;
        while (pairs_sent < PAIR_TARGET) begin
            phase++;
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: w = 512;
                5, 6:          w = 2 * $urandom_range(256, 350);
                7:             w = 4096;
                8:             w = $urandom_range(0, 8191);
                default:       w = 2 * $urandom_range(256, 2048);
            endcase
            case ($urandom_range(0, 9))
                0, 1, 2, 3: h = 1;
                4, 5, 6:    h = $urandom_range(2, 3);
                7:          h = 4096;
                8:          h = $urandom_range(0, 1) ? 0 : $urandom_range(4097, 8191);
                default:    h = $urandom_range(1, 4096);
            endcase
            case ($urandom_range(0, 9))
                0, 1, 2: p = 1500;
                3, 4:    p = 64;
                9:       p = $urandom_range(0, 2047);
                default: p = $urandom_range(64, 1500);
            endcase
            apply_setting(w, h, p);
            if (phase == 3) squeeze = 1'b1;
            chunk = (phase == 3) ? 60 : $urandom_range(10, 50);
            repeat (chunk) push_pair($urandom());
        end

        drain();
        repeat (TAIL_CYCLES) @(negedge aclk);

        $display("%0d pixel pairs sent under %0d register settings, one %0d-cycle hold-off",
                 pairs_sent, settings_run, SQUEEZE_CYCLES);
        $display("%0d words compared, %0d frame-end packet headers among them",
                 words_seen, frame_ends);
        if (failures == 0 && pending == 0) begin
            $display("rfc4175_video_packetizer_unit_tb: done, clean");
        end else begin
            $display("rfc4175_video_packetizer_unit_tb: done, errors");
        end
        $finish;
    end

endmodule
